// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the queue RTL.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every sampled edge.
`define TDQ_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define TDQ_ASSERT_NEXT(label, trig, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (expr)) \
		else $error(msg);

`endif

// ===== rtl/tdq_pkg.sv =====
// ---------------------------------------------------------------------------
// tdq_pkg: shared types and codes for the three-level priority deque
// Operation codes, status codes, priority levels and the control word
// that the top level broadcasts to every storage cell.
// ---------------------------------------------------------------------------
`default_nettype none

package tdq_pkg;

	// Operation requested by one input transfer.
	typedef enum logic [1:0] {
		MODE_INSERT       = 2'd0,
		MODE_REMOVE_FRONT = 2'd1,
		MODE_REMOVE_BACK  = 2'd2,
		MODE_CLEAR        = 2'd3
	} mode_t;

	// Result status.
	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_FULL    = 2'd1,
		STATUS_EMPTY   = 2'd2,
		STATUS_BAD_PRI = 2'd3
	} status_t;

	typedef logic [1:0] pri_t;

	localparam pri_t PRI_NONE = 2'd0;
	localparam pri_t PRI_LOW  = 2'd1;
	localparam pri_t PRI_MID  = 2'd2;
	localparam pri_t PRI_HIGH = 2'd3;

	// Control word seen by every cell in the same cycle.
	typedef struct packed {
		logic ins;       // an insert is taking effect this cycle
		logic pop_front; // the front entry is leaving this cycle
		pri_t pri;       // priority of the word being inserted
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/tdq_cell.sv =====
// ---------------------------------------------------------------------------
// tdq_cell: one storage slot of the priority deque
// Holds one word and its priority. On an insert it keeps its entry, takes
// the new word, or takes its left neighbour's entry; on a front removal it
// takes its right neighbour's entry.
// ---------------------------------------------------------------------------
`default_nettype none

module tdq_cell
	import tdq_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire cell_ctrl_t            ctrl,
	input  wire logic [DATA_WIDTH-1:0] new_data,
	input  wire logic                  occupied,
	input  wire logic                  prev_mark,
	input  wire logic [DATA_WIDTH-1:0] left_data,
	input  wire pri_t                  left_pri,
	input  wire logic [DATA_WIDTH-1:0] right_data,
	input  wire pri_t                  right_pri,
	output logic                       mark,
	output logic [DATA_WIDTH-1:0]      data,
	output pri_t                       pri
);

	logic [DATA_WIDTH-1:0] data_q;
	pri_t                  pri_q;

	// This slot lies at or behind the insert position. High-priority entries
	// always form a run at the front, so the mark is a thermometer along the row.
	always_comb begin
		case (ctrl.pri)
			PRI_HIGH: mark = 1'b1;
			PRI_MID:  mark = !(occupied && (pri_q == PRI_HIGH));
			default:  mark = !occupied;
		endcase
	end

	// Slot update: open a hole at the insert position or close up at the front.
	always_ff @(posedge clk) begin
		if (ctrl.ins && mark) begin
			if (prev_mark) begin
				data_q <= left_data;
				pri_q  <= left_pri;
			end else begin
				data_q <= new_data;
				pri_q  <= ctrl.pri;
			end
		end else if (ctrl.pop_front) begin
			data_q <= right_data;
			pri_q  <= right_pri;
		end
	end

	assign data = data_q;
	assign pri  = pri_q;

endmodule

`default_nettype wire

// ===== rtl/three_level_priority_deque_top.sv =====
// ---------------------------------------------------------------------------
// three_level_priority_deque_top: bounded deque ordered by three priorities
// A row of CAPACITY slots, front at slot 0. Priority 3 enters at the front,
// priority 2 behind the leading priority-3 run, priority 1 at the tail.
//
// Use: the input channel (in_valid, in_stall) carries mode, data_in and
// priority_req; the output channel (out_valid, out_stall) carries one result
// per input transfer: status, removed_data, removed_priority, entry_count
// and queue_empty. Results come out in input order.
// Result: registered, and presented in the cycle after its input transfer.
// Throughput: one operation per cycle while in_stall is low. Every slot decides
// locally and shifts in parallel with its neighbours in the same cycle, so the
// occupancy counter update is the only loop-carried path.
// Receiver stall: the result register holds its value; a new input is taken
// in the same cycle that the pending result is transferred, and in_stall is
// high only while a result waits and out_stall is high.
// Reset: arst_n clears the occupancy count and the result valid flag at
// once; the queue is empty and ready as soon as arst_n is released. Slot
// contents are not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module three_level_priority_deque_top
	import tdq_pkg::*;
#(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  mode,
	input  wire logic [31:0] data_in,
	input  wire logic [1:0]  priority_req,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [31:0]      removed_data,
	output logic [1:0]       removed_priority,
	output logic [4:0]       entry_count,
	output logic             queue_empty
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_next;

	logic          out_valid_q;
	status_t       status_q;
	logic [31:0]   removed_data_q;
	pri_t          removed_pri_q;
	logic [4:0]    entry_count_q;
	logic          queue_empty_q;

	logic          accept;
	logic          is_empty;
	logic          is_full;
	status_t       status_next;
	logic [DATA_WIDTH-1:0] rd_next;
	pri_t          rp_next;
	cell_ctrl_t    ctrl;
	logic [DATA_WIDTH-1:0] new_data;
	logic [DATA_WIDTH-1:0] back_data;
	pri_t          back_pri;
	logic [63:0]   din_wide;
	logic [63:0]   rd_wide;
	logic [31:0]   count_wide;

	logic [CAPACITY-1:0]   occupied;
	logic [CAPACITY-1:0]   last;
	logic [CAPACITY-1:0]   mark;
	logic [CAPACITY-1:0]   prev_mark;
	logic [CAPACITY-1:0]   high_run;
	logic [DATA_WIDTH-1:0] cell_data  [CAPACITY];
	pri_t                  cell_pri   [CAPACITY];
	logic [DATA_WIDTH-1:0] left_data  [CAPACITY];
	pri_t                  left_pri   [CAPACITY];
	logic [DATA_WIDTH-1:0] right_data [CAPACITY];
	pri_t                  right_pri  [CAPACITY];

	// Handshake: a new transfer is taken unless a result is waiting and stalled.
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CW'(CAPACITY));

	// Only the low DATA_WIDTH bits of the inserted word are kept.
	assign din_wide = {32'd0, data_in};
	assign new_data = din_wide[DATA_WIDTH-1:0];

	// Per-slot occupancy and the tail flag, derived from the count.
	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_slot
			assign occupied[gi] = (CW'(gi) < count_q);
			assign high_run[gi] = occupied[gi] && (cell_pri[gi] == PRI_HIGH);
			if (gi == CAPACITY - 1) begin : g_end
				assign last[gi]       = occupied[gi];
				assign right_data[gi] = '0;
				assign right_pri[gi]  = PRI_NONE;
			end else begin : g_mid
				assign last[gi]       = occupied[gi] && !occupied[gi+1];
				assign right_data[gi] = cell_data[gi+1];
				assign right_pri[gi]  = cell_pri[gi+1];
			end
			if (gi == 0) begin : g_head
				assign prev_mark[gi] = 1'b0;
				assign left_data[gi] = '0;
				assign left_pri[gi]  = PRI_NONE;
			end else begin : g_tail
				assign prev_mark[gi] = mark[gi-1];
				assign left_data[gi] = cell_data[gi-1];
				assign left_pri[gi]  = cell_pri[gi-1];
			end

			tdq_cell #(
				.DATA_WIDTH(DATA_WIDTH)
			) u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.new_data  (new_data),
				.occupied  (occupied[gi]),
				.prev_mark (prev_mark[gi]),
				.left_data (left_data[gi]),
				.left_pri  (left_pri[gi]),
				.right_data(right_data[gi]),
				.right_pri (right_pri[gi]),
				.mark      (mark[gi]),
				.data      (cell_data[gi]),
				.pri       (cell_pri[gi])
			);
		end
	endgenerate

	// The tail entry, picked by its one-hot flag.
	always_comb begin
		back_data = '0;
		back_pri  = PRI_NONE;
		for (int i = 0; i < CAPACITY; i++) begin
			back_data = back_data | ({DATA_WIDTH{last[i]}} & cell_data[i]);
			back_pri  = back_pri | ({2{last[i]}} & cell_pri[i]);
		end
	end

	// Operation decode: status, removed entry, new count and cell control.
	always_comb begin
		status_next    = STATUS_OK;
		rd_next        = '0;
		rp_next        = PRI_NONE;
		count_next     = count_q;
		ctrl.ins       = 1'b0;
		ctrl.pop_front = 1'b0;
		ctrl.pri       = priority_req;
		case (mode)
			MODE_INSERT: begin
				if (priority_req == PRI_NONE) begin
					status_next = STATUS_BAD_PRI;
				end else if (is_full) begin
					status_next = STATUS_FULL;
				end else begin
					ctrl.ins   = accept;
					count_next = count_q + CW'(1);
				end
			end
			MODE_REMOVE_FRONT: begin
				if (is_empty) begin
					status_next = STATUS_EMPTY;
				end else begin
					rd_next        = cell_data[0];
					rp_next        = cell_pri[0];
					ctrl.pop_front = accept;
					count_next     = count_q - CW'(1);
				end
			end
			MODE_REMOVE_BACK: begin
				if (is_empty) begin
					status_next = STATUS_EMPTY;
				end else begin
					rd_next    = back_data;
					rp_next    = back_pri;
					count_next = count_q - CW'(1);
				end
			end
			default: begin
				if (is_empty) begin
					status_next = STATUS_EMPTY;
				end else begin
					count_next = '0;
				end
			end
		endcase
	end

	assign rd_wide    = 64'(rd_next);
	assign count_wide = 32'(count_next);

	// Occupancy counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_next;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q       <= status_next;
			removed_data_q <= rd_wide[31:0];
			removed_pri_q  <= rp_next;
			entry_count_q  <= count_wide[4:0];
			queue_empty_q  <= (count_next == '0);
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign removed_data     = removed_data_q;
	assign removed_priority = removed_pri_q;
	assign entry_count      = entry_count_q;
	assign queue_empty      = queue_empty_q;

	// Checks on the queue's own bookkeeping.
	`include "assert_macros.svh"

	`TDQ_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(CAPACITY), "occupancy above capacity")
	`TDQ_ASSERT_ALWAYS(a_high_prefix, (high_run & (high_run + CAPACITY'(1))) == '0, "priority-3 run broken")
	`TDQ_ASSERT_NEXT(a_result_after_transfer, accept, out_valid_q, "no result after transfer")
	`TDQ_ASSERT_NEXT(a_clear_empties, accept && (mode == MODE_CLEAR), count_q == '0, "clear left entries")

endmodule

`default_nettype wire
